// ----- rtl/mfb_pkg.sv -----
// Shared types, widths and codes for the monochrome frame store draw engine.
`timescale 1ns / 1ps

package mfb_pkg;

    // Defaults for the top-level size parameters
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 512;

    // Fixed widths that follow from the item and register fields
    localparam int FUNC_W = 3;
    localparam int COORD_W = 16;
    localparam int SIZE_W = 11;
    localparam int MODE_W = 2;
    localparam int RADDR_W = 16;
    localparam int DATA_W = 8;
    localparam int FW_W = 11;
    localparam int FH_W = 10;
    localparam int ROT_W = 1;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 11;

    localparam int W8_W = FW_W - 3;       // bytes per row
    localparam int NB_W = W8_W + FH_W;    // bytes in a frame
    localparam int CRD_W = 18;            // pixel coordinate after offset and rotation
    localparam int PRD_W = CRD_W + W8_W + 1;

    // Command codes on the func field
    localparam logic [FUNC_W-1:0] FUNC_FILL   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_INVERT = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_MIRROR = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_FLIP   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_READ   = 3'd4;

    // Pixel modes
    localparam logic [MODE_W-1:0] PM_CLEAR  = 2'd0;
    localparam logic [MODE_W-1:0] PM_SET    = 2'd1;
    localparam logic [MODE_W-1:0] PM_TOGGLE = 2'd2;
    localparam logic [MODE_W-1:0] PM_GRAY   = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROTATE       = 2'd2;

    localparam logic [FW_W-1:0]  RST_FRAME_WIDTH  = 11'd640;
    localparam logic [FH_W-1:0]  RST_FRAME_HEIGHT = 10'd384;

    typedef enum logic [2:0] {
        OP_FILL,
        OP_INVERT,
        OP_MIRROR,
        OP_FLIP,
        OP_READ,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t                        op;
        logic signed [COORD_W-1:0]  left;
        logic signed [COORD_W-1:0]  top;
        logic [SIZE_W-1:0]          width;
        logic [SIZE_W-1:0]          height;
        logic [MODE_W-1:0]          mode;
        logic [RADDR_W-1:0]         addr;
    } cmd_t;

    typedef struct packed {
        logic [FW_W-1:0]  frame_width;
        logic [FH_W-1:0]  frame_height;
        logic [ROT_W-1:0] rotate_quarter;
    } cfg_t;

    // Back end to front end handshake
    typedef struct packed {
        logic pop;
        logic clearing;
    } bk_ctl_t;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_SETUP,
        S_START,
        S_FADDR,
        S_FRD,
        S_FWR,
        S_INV_RD,
        S_INV_WR,
        S_SW_RDA,
        S_SW_RDB,
        S_SW_WRA,
        S_SW_WRB,
        S_RD,
        S_RD_WAIT,
        S_DONE
    } bk_state_t;

endpackage

// ----- rtl/mfb_front.sv -----
// Front end: takes command items, decodes func and holds them in a two-entry queue.
`timescale 1ns / 1ps

module mfb_front
    import mfb_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [FUNC_W-1:0]          func,
    input  logic signed [COORD_W-1:0]  rect_left,
    input  logic signed [COORD_W-1:0]  rect_top,
    input  logic [SIZE_W-1:0]          rect_width,
    input  logic [SIZE_W-1:0]          rect_height,
    input  logic [MODE_W-1:0]          pixel_mode,
    input  logic [RADDR_W-1:0]         read_address,
    input  bk_ctl_t                    bk_ctl,
    output logic                       cmd_valid,
    output cmd_t                       cmd
);

    localparam int DEPTH = 2;

    cmd_t       q_reg [DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    op_t        op_dec;

    always_comb
    begin
        unique case (func)
            FUNC_FILL:   op_dec = OP_FILL;
            FUNC_INVERT: op_dec = OP_INVERT;
            FUNC_MIRROR: op_dec = OP_MIRROR;
            FUNC_FLIP:   op_dec = OP_FLIP;
            FUNC_READ:   op_dec = OP_READ;
            default:     op_dec = OP_NOP;
        endcase
    end

    assign in_stall  = (count_reg == 2'(DEPTH)) || bk_ctl.clearing;
    assign push      = in_valid && !in_stall;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ bk_ctl.pop;
        count_next  = count_reg + 2'(push) - 2'(bk_ctl.pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= '{op: op_dec, left: rect_left, top: rect_top,
                                   width: rect_width, height: rect_height,
                                   mode: pixel_mode, addr: read_address};
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'(DEPTH)) else $error("queue count beyond depth");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        bk_ctl.pop |-> count_reg != 2'd0) else $error("pop from empty queue");
    a_no_take_clr: assert property (@(posedge clk) disable iff (!rst_n)
        bk_ctl.clearing |-> !push) else $error("item taken during clear");

endmodule

// ----- rtl/mfb_back.sv -----
// Back end: frame store, clearing pass and the command sequencer.
`timescale 1ns / 1ps

module mfb_back
    import mfb_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               cmd_valid,
    input  cmd_t               cmd,
    output bk_ctl_t            bk_ctl,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [DATA_W-1:0]  read_data
);

    localparam int MAX_W8      = MAX_WIDTH / 8;
    localparam int STORE_BYTES = MAX_W8 * MAX_HEIGHT;
    localparam int ADDR_W      = $clog2(STORE_BYTES);

    function automatic logic [DATA_W-1:0] bit_rev(input logic [DATA_W-1:0] b);
        logic [DATA_W-1:0] r;
        for (int n = 0; n < DATA_W; n++)
        begin
            r[n] = b[DATA_W-1-n];
        end
        return r;
    endfunction

    logic [DATA_W-1:0] mem [STORE_BYTES];
    logic [DATA_W-1:0] rd_data_reg;
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [DATA_W-1:0] mem_wdata;

    bk_state_t state_reg, state_next;
    cmd_t      cmd_reg, cmd_next;
    logic [W8_W-1:0]   w8_reg, w8_next;
    logic [FH_W-1:0]   h_reg, h_next;
    logic [NB_W-1:0]   nbytes_reg, nbytes_next;
    logic [SIZE_W-1:0] i_reg, i_next, j_reg, j_next;
    logic [NB_W-1:0]   k_reg, k_next;
    logic [W8_W-1:0]   a_reg, a_next;
    logic [FH_W-1:0]   row_reg, row_next;
    logic [NB_W-1:0]   base_a_reg, base_a_next, base_b_reg, base_b_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic signed [PRD_W-1:0] prod_reg, prod_next;
    logic signed [CRD_W-1:0] col_reg, col_next;
    logic [2:0]        bit_reg, bit_next;
    logic              on_reg, on_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [DATA_W-1:0] tmp_reg, tmp_next, res_reg, res_next;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_data_reg, out_data_next;

    logic signed [CRD_W-1:0] px, py, xr, yr, full_w;
    logic signed [PRD_W-1:0] idx;
    logic [NB_W-1:0]   addr_a, addr_b;
    logic [DATA_W-1:0] mask;
    logic              last_j, last_i, is_mirror, pop;
    logic [W8_W-1:0]   w8_cfg;
    logic [FH_W-1:0]   h_cfg;

    assign w8_cfg = (32'(cfg.frame_width[FW_W-1:3]) > MAX_W8) ? W8_W'(MAX_W8)
                                                              : cfg.frame_width[FW_W-1:3];
    assign h_cfg  = (32'(cfg.frame_height) > MAX_HEIGHT) ? FH_W'(MAX_HEIGHT)
                                                        : cfg.frame_height;

    // Pixel coordinates, optional quarter turn
    assign px     = CRD_W'(cmd_reg.left) + CRD_W'($signed({1'b0, i_reg}));
    assign py     = CRD_W'(cmd_reg.top) + CRD_W'($signed({1'b0, j_reg}));
    assign full_w = CRD_W'($signed({1'b0, w8_reg, 3'b000}));
    assign xr     = cfg.rotate_quarter[0] ? (full_w - CRD_W'(1) - py) : px;
    assign yr     = cfg.rotate_quarter[0] ? px : py;
    assign idx    = PRD_W'(col_reg) + prod_reg;
    assign mask   = 8'h80 >> bit_reg;
    assign last_j = (j_reg + SIZE_W'(1)) == cmd_reg.height;
    assign last_i = (i_reg + SIZE_W'(1)) == cmd_reg.width;
    assign is_mirror = (cmd_reg.op == OP_MIRROR);
    assign addr_a = base_a_reg + NB_W'(a_reg);
    assign addr_b = is_mirror ? (base_a_reg + NB_W'(w8_reg) - NB_W'(1) - NB_W'(a_reg))
                              : (base_b_reg + NB_W'(a_reg));

    assign pop    = (state_reg == S_IDLE) && cmd_valid;
    assign bk_ctl = '{pop: pop, clearing: (state_reg == S_CLR)};

    always_comb
    begin
        state_next = state_reg;
        cmd_next = cmd_reg;
        w8_next = w8_reg;
        h_next = h_reg;
        nbytes_next = nbytes_reg;
        i_next = i_reg;
        j_next = j_reg;
        k_next = k_reg;
        a_next = a_reg;
        row_next = row_reg;
        base_a_next = base_a_reg;
        base_b_next = base_b_reg;
        clr_next = clr_reg;
        prod_next = prod_reg;
        col_next = col_reg;
        bit_next = bit_reg;
        on_next = on_reg;
        idx_next = idx_reg;
        tmp_next = tmp_reg;
        res_next = res_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next = out_data_reg;
        mem_we = 1'b0;
        mem_re = 1'b0;
        mem_waddr = '0;
        mem_raddr = '0;
        mem_wdata = '0;

        unique case (state_reg)
            S_CLR:
            begin
                mem_we = 1'b1;
                mem_waddr = clr_reg;
                clr_next = clr_reg + ADDR_W'(1);
                if (32'(clr_reg) == STORE_BYTES - 1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next = cmd;
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                w8_next = w8_cfg;
                h_next = h_cfg;
                nbytes_next = NB_W'(w8_cfg * h_cfg);
                state_next = S_START;
            end
            S_START:
            begin
                res_next = '0;
                i_next = '0;
                j_next = '0;
                k_next = '0;
                a_next = '0;
                row_next = '0;
                base_a_next = '0;
                base_b_next = nbytes_reg - NB_W'(w8_reg);
                unique case (cmd_reg.op)
                    OP_FILL:
                        state_next = (cmd_reg.width == '0 || cmd_reg.height == '0)
                                     ? S_DONE : S_FADDR;
                    OP_INVERT:
                        state_next = (nbytes_reg == '0) ? S_DONE : S_INV_RD;
                    OP_MIRROR:
                        state_next = (nbytes_reg == '0) ? S_DONE : S_SW_RDA;
                    OP_FLIP:
                        state_next = (w8_reg == '0 || h_reg < FH_W'(2)) ? S_DONE : S_SW_RDA;
                    OP_READ:
                        state_next = S_RD;
                    default:
                        state_next = S_DONE;
                endcase
            end
            S_FADDR:
            begin
                prod_next = $signed({1'b0, w8_reg}) * yr;
                col_next = xr >>> 3;
                bit_next = xr[2:0];
                on_next = (cmd_reg.mode == PM_SET) ||
                          ((cmd_reg.mode == PM_GRAY) && (xr[0] ^ yr[0]));
                state_next = S_FRD;
            end
            S_FRD, S_FWR:
            begin
                if (state_reg == S_FRD &&
                    !(idx[PRD_W-1] || idx >= PRD_W'($signed({1'b0, nbytes_reg}))))
                begin
                    mem_re = 1'b1;
                    mem_raddr = ADDR_W'(idx);
                    idx_next = ADDR_W'(idx);
                    state_next = S_FWR;
                end
                else
                begin
                    if (state_reg == S_FWR)
                    begin
                        mem_we = 1'b1;
                        mem_waddr = idx_reg;
                        if (cmd_reg.mode == PM_TOGGLE)
                            mem_wdata = rd_data_reg ^ mask;
                        else if (on_reg)
                            mem_wdata = rd_data_reg | mask;
                        else
                            mem_wdata = rd_data_reg & ~mask;
                    end
                    // next pixel, column by column
                    if (!last_j)
                    begin
                        j_next = j_reg + SIZE_W'(1);
                        state_next = S_FADDR;
                    end
                    else
                    begin
                        j_next = '0;
                        i_next = i_reg + SIZE_W'(1);
                        state_next = last_i ? S_DONE : S_FADDR;
                    end
                end
            end
            S_INV_RD:
            begin
                mem_re = 1'b1;
                mem_raddr = ADDR_W'(k_reg);
                state_next = S_INV_WR;
            end
            S_INV_WR:
            begin
                mem_we = 1'b1;
                mem_waddr = ADDR_W'(k_reg);
                mem_wdata = rd_data_reg ^ 8'hff;
                k_next = k_reg + NB_W'(1);
                state_next = ((k_reg + NB_W'(1)) == nbytes_reg) ? S_DONE : S_INV_RD;
            end
            S_SW_RDA:
            begin
                mem_re = 1'b1;
                mem_raddr = ADDR_W'(addr_a);
                state_next = S_SW_RDB;
            end
            S_SW_RDB:
            begin
                mem_re = 1'b1;
                mem_raddr = ADDR_W'(addr_b);
                tmp_next = rd_data_reg;
                state_next = S_SW_WRA;
            end
            S_SW_WRA:
            begin
                mem_we = 1'b1;
                mem_waddr = ADDR_W'(addr_a);
                mem_wdata = is_mirror ? bit_rev(rd_data_reg) : rd_data_reg;
                state_next = S_SW_WRB;
            end
            S_SW_WRB:
            begin
                mem_we = 1'b1;
                mem_waddr = ADDR_W'(addr_b);
                mem_wdata = is_mirror ? bit_rev(tmp_reg) : tmp_reg;
                state_next = S_SW_RDA;
                if (is_mirror)
                begin
                    // middle byte of an odd row is its own partner
                    if (W8_W'(a_reg + W8_W'(1)) < W8_W'((9'(w8_reg) + 9'd1) >> 1))
                        a_next = a_reg + W8_W'(1);
                    else
                    begin
                        a_next = '0;
                        row_next = row_reg + FH_W'(1);
                        base_a_next = base_a_reg + NB_W'(w8_reg);
                        if ((row_reg + FH_W'(1)) == h_reg)
                            state_next = S_DONE;
                    end
                end
                else
                begin
                    if ((a_reg + W8_W'(1)) != w8_reg)
                        a_next = a_reg + W8_W'(1);
                    else
                    begin
                        a_next = '0;
                        row_next = row_reg + FH_W'(1);
                        base_a_next = base_a_reg + NB_W'(w8_reg);
                        base_b_next = base_b_reg - NB_W'(w8_reg);
                        if ((row_reg + FH_W'(1)) == (h_reg >> 1))
                            state_next = S_DONE;
                    end
                end
            end
            S_RD:
            begin
                if (32'(cmd_reg.addr) < STORE_BYTES)
                begin
                    mem_re = 1'b1;
                    mem_raddr = ADDR_W'(cmd_reg.addr);
                    state_next = S_RD_WAIT;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_RD_WAIT:
            begin
                res_next = rd_data_reg;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_data_next = res_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            clr_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        w8_reg <= w8_next;
        h_reg <= h_next;
        nbytes_reg <= nbytes_next;
        i_reg <= i_next;
        j_reg <= j_next;
        k_reg <= k_next;
        a_reg <= a_next;
        row_reg <= row_next;
        base_a_reg <= base_a_next;
        base_b_reg <= base_b_next;
        prod_reg <= prod_next;
        col_reg <= col_next;
        bit_reg <= bit_next;
        on_reg <= on_next;
        idx_reg <= idx_next;
        tmp_reg <= tmp_next;
        res_reg <= res_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= mem[mem_raddr];
    end

    assign out_valid = out_valid_reg;
    assign read_data = out_data_reg;

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> state_reg == S_IDLE && cmd_valid) else $error("pop outside idle");
    a_fill_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && state_reg == S_FWR) |-> NB_W'(idx_reg) < nbytes_reg)
        else $error("fill write outside frame");
    a_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && cmd_reg.op != OP_READ) |-> res_reg == '0)
        else $error("non-read result not zero");
    a_no_wr_rd_clash: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLR |-> !mem_re && !out_valid_reg)
        else $error("activity during clearing pass");

endmodule

// ----- rtl/mono_framebuffer_draw_engine_top.sv -----
// Top level of the monochrome frame store draw engine.
`timescale 1ns / 1ps

// Monochrome 1 bpp frame store with a command engine (MSB is the leftmost pixel).
// Input channel (in_valid / in_stall) carries one command item: fill rectangle,
// invert, mirror, flip or read one byte. Output channel (out_valid / out_stall)
// returns exactly one item per command; read_data is the byte for a read and
// zero otherwise. Results come back in command order.
// A front end decodes items into a two-entry queue; the back end runs them one
// at a time against a single-port store (one access per cycle), so the store
// port sets the pace of each command:
//   fill   : a read and a write per pixel in the frame, no access for a skipped pixel
//   invert : a read and a write per frame byte
//   mirror, flip : two reads and two writes per byte pair
//   read   : one store read for an address inside the store
// plus setup and result handoff for each command.
// Reset: config goes to 640 x 384, no rotation, and the store is cleared by a
// pass over all MAX_WIDTH/8*MAX_HEIGHT bytes (65536 by default), during which
// in_stall is high. Config writes (cfg_we) are taken at any time but should be
// made while idle. A stalled result is held in the output register; the engine
// keeps the next finished result until the register frees, and the queue keeps
// taking items until full.
module mono_framebuffer_draw_engine_top
    import mfb_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [FUNC_W-1:0]          func,
    input  logic signed [COORD_W-1:0]  rect_left,
    input  logic signed [COORD_W-1:0]  rect_top,
    input  logic [SIZE_W-1:0]          rect_width,
    input  logic [SIZE_W-1:0]          rect_height,
    input  logic [MODE_W-1:0]          pixel_mode,
    input  logic [RADDR_W-1:0]         read_address,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [DATA_W-1:0]          read_data
);

    cfg_t    cfg_reg, cfg_next;
    bk_ctl_t bk_ctl;
    logic    cmd_valid;
    cmd_t    cmd;

    // config registers; unknown indexes are ignored
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  cfg_next.frame_width = cfg_data[FW_W-1:0];
                REG_FRAME_HEIGHT: cfg_next.frame_height = cfg_data[FH_W-1:0];
                REG_ROTATE:       cfg_next.rotate_quarter = cfg_data[ROT_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '{frame_width: RST_FRAME_WIDTH, frame_height: RST_FRAME_HEIGHT,
                         rotate_quarter: '0};
        else
            cfg_reg <= cfg_next;
    end

    mfb_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .rect_left    (rect_left),
        .rect_top     (rect_top),
        .rect_width   (rect_width),
        .rect_height  (rect_height),
        .pixel_mode   (pixel_mode),
        .read_address (read_address),
        .bk_ctl       (bk_ctl),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd)
    );

    mfb_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .bk_ctl    (bk_ctl),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .read_data (read_data)
    );

endmodule
